@@ design/fifd_pkg.sv @@
// Shared constants, codes and types of the stop-bit integer field decoder.
`default_nettype none
package fifd_pkg;

    localparam int DEF_FIELD_SLOTS   = 64;
    localparam int DEF_MAX_INT_BYTES = 9;

    localparam int SLOT_W  = 6;
    localparam int VALUE_W = 64;
    localparam int OP_W    = 3;
    localparam int BYTE_W  = 8;
    localparam int GROUP_W = 7;
    localparam int STOP_BIT = 7;
    localparam int SIGN_BIT = 6;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
    localparam logic [OP_W-1:0] OP_COPY  = 3'd1;
    localparam logic [OP_W-1:0] OP_INCR  = 3'd2;
    localparam logic [OP_W-1:0] OP_DELTA = 3'd3;
    localparam logic [OP_W-1:0] OP_CONST = 3'd4;

    localparam logic [1:0] SS_UNDEF    = 2'd0;
    localparam logic [1:0] SS_ASSIGNED = 2'd1;
    localparam logic [1:0] SS_EMPTY    = 2'd2;

    localparam logic [1:0] RES_OK       = 2'd0;
    localparam logic [1:0] RES_OVERLONG = 2'd1;
    localparam logic [1:0] RES_MISSING  = 2'd2;
    localparam logic [1:0] RES_BADOP    = 2'd3;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [VALUE_W-1:0] value;
        logic               present;
        logic [1:0]         status;
    } result_t;

endpackage
`default_nettype wire

@@ design/fifd_out_queue.sv @@
// Four-entry result queue that decouples the decode pipeline from the output stall.
`default_nettype none
module fifd_out_queue (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    input  wire fifd_pkg::result_t         push_data,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output fifd_pkg::result_t              out_data,
    output logic [fifd_pkg::OUT_CNT_W-1:0] count
);
    import fifd_pkg::*;

    result_t                entry_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   wr_ptr_reg;
    logic [OUT_PTR_W-1:0]   rd_ptr_reg;
    logic [OUT_CNT_W-1:0]   count_reg;
    logic [OUT_CNT_W-1:0]   count_next;
    logic                   pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + OUT_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - OUT_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + OUT_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OUT_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

@@ design/fast_integer_field_decoder.sv @@
// Top level of the stop-bit integer field decoder with its slot dictionary memory.
//
//  Channel  Valid      Stall      Payload
//  input    in_valid   in_stall   opcode, stream_byte, slot, operator_kind, is_signed,
//                                 is_mandatory, presence_bit, has_initial, initial_value
//  output   out_valid  out_stall  field_slot, field_value, is_present, status
//
// One input transfer can be taken every cycle while in_stall is low; the item and its
// dictionary memory read are registered in the second stage, and its result then in the queue.
// Each slot is read, modified and written back in one pass; a one-entry bypass covers
// back-to-back transfers on the same slot.
// After reset a clearing pass writes every slot; in_stall is high while it runs.
// in_stall also rises when the four-entry result queue could overflow.
`default_nettype none
module fast_integer_field_decoder #(
    parameter int FIELD_SLOTS   = fifd_pkg::DEF_FIELD_SLOTS,
    parameter int MAX_INT_BYTES = fifd_pkg::DEF_MAX_INT_BYTES
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        opcode,
    input  wire logic [fifd_pkg::BYTE_W-1:0]  stream_byte,
    input  wire logic [fifd_pkg::SLOT_W-1:0]  slot,
    input  wire logic [fifd_pkg::OP_W-1:0]    operator_kind,
    input  wire logic                        is_signed,
    input  wire logic                        is_mandatory,
    input  wire logic                        presence_bit,
    input  wire logic                        has_initial,
    input  wire logic [fifd_pkg::VALUE_W-1:0] initial_value,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [fifd_pkg::SLOT_W-1:0]       field_slot,
    output logic [fifd_pkg::VALUE_W-1:0]      field_value,
    output logic                             is_present,
    output logic [1:0]                       status
);
    import fifd_pkg::*;

    localparam int IDX_W     = (FIELD_SLOTS > 1) ? $clog2(FIELD_SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_INT_BYTES + 1);
    localparam int MAX_WRAPS = ((1 << SLOT_W) - 1) / FIELD_SLOTS;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    typedef enum logic [2:0] {
        K_CONST,
        K_HOLD,
        K_FINISH,
        K_OVERLONG,
        K_BADOP
    } kind_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [VALUE_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic              mand;
        logic              sgn;
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
    } desc_t;

    function automatic logic [IDX_W-1:0] slot_to_index(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        r = s;
        for (int k = 1; k <= MAX_WRAPS; k++)
        begin
            if (int'(s) >= k * FIELD_SLOTS)
            begin
                r = s - SLOT_W'(k * FIELD_SLOTS);
            end
        end
        return IDX_W'(r);
    endfunction

    state_t             state_reg;
    state_t             state_next;
    logic [IDX_W-1:0]   clr_idx_reg;

    logic [VALUE_W-1:0] acc_reg;
    logic [VALUE_W-1:0] acc_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    desc_t              desc_reg;
    desc_t              desc_next;
    logic               active_reg;
    logic               active_next;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    kind_t              s1_kind_reg;
    kind_t              s1_kind_next;
    logic [SLOT_W-1:0]  s1_slot_reg;
    logic [SLOT_W-1:0]  s1_slot_next;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic [OP_W-1:0]    s1_op_reg;
    logic [OP_W-1:0]    s1_op_next;
    logic               s1_mand_reg;
    logic               s1_mand_next;
    logic               s1_pres_reg;
    logic               s1_init_reg;
    logic [VALUE_W-1:0] s1_data_reg;
    logic [VALUE_W-1:0] s1_data_next;
    logic               s1_empty_reg;

    entry_t             mem [FIELD_SLOTS];
    entry_t             rd_entry_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_entry;
    logic               byp_valid_reg;
    logic [IDX_W-1:0]   byp_addr_reg;
    entry_t             byp_entry_reg;

    logic               accept;
    logic [IDX_W-1:0]   in_idx;
    logic [IDX_W-1:0]   held_idx;
    logic [VALUE_W-1:0] acc_base;
    logic [VALUE_W-1:0] acc_shift;
    logic [CNT_W-1:0]   cnt_inc;
    logic               v_neg;
    logic               v_zero;
    logic [VALUE_W-1:0] v_adj;

    entry_t             cur;
    entry_t             upd;
    logic               s1_write;
    logic [VALUE_W-1:0] add_sum;
    result_t            res;
    result_t            q_data;
    logic [OUT_CNT_W-1:0] q_count;

    assign in_idx   = slot_to_index(slot);
    assign held_idx = slot_to_index(desc_reg.slot);
    assign in_stall = (state_reg != ST_RUN)
                   || ((q_count + OUT_CNT_W'(s1_valid_reg)) >= OUT_CNT_W'(OUT_DEPTH - 1));
    assign accept   = in_valid && !in_stall;
    assign rd_addr  = opcode ? held_idx : in_idx;

    // Stop-bit accumulation of one data byte and the optional-field offset.
    assign acc_base  = ((cnt_reg == '0) && desc_reg.sgn && stream_byte[SIGN_BIT]) ? '1 : acc_reg;
    assign acc_shift = {acc_base[VALUE_W-GROUP_W-1:0], stream_byte[GROUP_W-1:0]};
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign v_neg     = desc_reg.sgn && acc_shift[VALUE_W-1];
    assign v_zero    = (acc_shift == '0);
    assign v_adj     = (!desc_reg.mand && !v_zero && !v_neg) ? acc_shift - VALUE_W'(1) : acc_shift;

    always_comb
    begin
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        desc_next     = desc_reg;
        active_next   = active_reg;
        s1_valid_next = 1'b0;
        s1_kind_next  = K_BADOP;
        s1_slot_next  = slot;
        s1_op_next    = operator_kind;
        s1_mand_next  = is_mandatory;
        s1_data_next  = initial_value;
        if (accept)
        begin
            if (opcode)
            begin
                if (active_reg)
                begin
                    acc_next     = acc_shift;
                    cnt_next     = cnt_inc;
                    s1_slot_next = desc_reg.slot;
                    s1_op_next   = desc_reg.op;
                    s1_mand_next = desc_reg.mand;
                    s1_data_next = v_adj;
                    if (stream_byte[STOP_BIT])
                    begin
                        active_next   = 1'b0;
                        s1_valid_next = 1'b1;
                        s1_kind_next  = K_FINISH;
                    end
                    else if (cnt_inc >= CNT_W'(MAX_INT_BYTES))
                    begin
                        active_next   = 1'b0;
                        s1_valid_next = 1'b1;
                        s1_kind_next  = K_OVERLONG;
                    end
                end
            end
            else
            begin
                active_next = 1'b0;
                if (operator_kind > OP_CONST)
                begin
                    s1_valid_next = 1'b1;
                    s1_kind_next  = K_BADOP;
                end
                else if (operator_kind == OP_CONST)
                begin
                    s1_valid_next = 1'b1;
                    s1_kind_next  = K_CONST;
                end
                else if (((operator_kind == OP_COPY) || (operator_kind == OP_INCR))
                         && !presence_bit)
                begin
                    s1_valid_next = 1'b1;
                    s1_kind_next  = K_HOLD;
                end
                else
                begin
                    desc_next   = '{mand: is_mandatory, sgn: is_signed,
                                    op: operator_kind, slot: slot};
                    acc_next    = '0;
                    cnt_next    = '0;
                    active_next = 1'b1;
                end
            end
        end
    end

    // Read, modify and write back the slot entry of the item in the second stage.
    assign cur     = (byp_valid_reg && (byp_addr_reg == s1_idx_reg)) ? byp_entry_reg
                                                                     : rd_entry_reg;
    assign add_sum = cur.value + ((s1_kind_reg == K_HOLD) ? VALUE_W'(1) : s1_data_reg);

    always_comb
    begin
        upd      = cur;
        s1_write = 1'b0;
        res      = '{slot: s1_slot_reg, value: '0, present: 1'b0, status: RES_OK};
        case (s1_kind_reg)
            K_CONST:
            begin
                s1_write = 1'b1;
                if (cur.status != SS_ASSIGNED)
                begin
                    upd.value = s1_data_reg;
                end
                upd.status = (!s1_mand_reg && !s1_pres_reg) ? SS_EMPTY : SS_ASSIGNED;
            end
            K_HOLD:
            begin
                case (cur.status)
                    SS_UNDEF:
                    begin
                        if (s1_init_reg)
                        begin
                            s1_write = 1'b1;
                            upd      = '{status: SS_ASSIGNED, value: s1_data_reg};
                        end
                        else if (s1_mand_reg)
                        begin
                            res.status = RES_MISSING;
                        end
                        else
                        begin
                            s1_write   = 1'b1;
                            upd.status = SS_EMPTY;
                        end
                    end
                    SS_ASSIGNED:
                    begin
                        if (s1_op_reg == OP_INCR)
                        begin
                            s1_write  = 1'b1;
                            upd.value = add_sum;
                        end
                    end
                    SS_EMPTY:
                    begin
                        if (s1_mand_reg)
                        begin
                            res.status = RES_MISSING;
                        end
                    end
                    default:
                    begin
                        s1_write = 1'b0;
                    end
                endcase
            end
            K_FINISH:
            begin
                s1_write = 1'b1;
                if (s1_op_reg == OP_DELTA)
                begin
                    upd = '{status: SS_ASSIGNED, value: add_sum};
                end
                else
                begin
                    upd = '{status: s1_empty_reg ? SS_EMPTY : SS_ASSIGNED, value: s1_data_reg};
                end
            end
            K_OVERLONG:
            begin
                res.status = RES_OVERLONG;
            end
            K_BADOP:
            begin
                res.status = RES_BADOP;
            end
            default:
            begin
                res.status = RES_BADOP;
            end
        endcase
        if ((s1_kind_reg == K_CONST) || (s1_kind_reg == K_FINISH)
            || ((s1_kind_reg == K_HOLD) && (res.status == RES_OK)))
        begin
            res.present = (upd.status == SS_ASSIGNED);
            res.value   = (upd.status == SS_ASSIGNED) ? upd.value : '0;
        end
    end

    assign wr_en    = (state_reg == ST_CLEAR) || (s1_valid_reg && s1_write);
    assign wr_addr  = (state_reg == ST_CLEAR) ? clr_idx_reg : s1_idx_reg;
    assign wr_entry = (state_reg == ST_CLEAR) ? '{status: SS_UNDEF, value: '0} : upd;

    always_ff @(posedge clk)
    begin
        rd_entry_reg <= mem[rd_addr];
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if ((state_reg == ST_CLEAR) && (clr_idx_reg == IDX_W'(FIELD_SLOTS - 1)))
        begin
            state_next = ST_RUN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            desc_reg      <= '0;
            active_reg    <= 1'b0;
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
            end
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            desc_reg      <= desc_next;
            active_reg    <= active_next;
            s1_valid_reg  <= s1_valid_next;
            byp_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_kind_reg   <= s1_kind_next;
        s1_slot_reg   <= s1_slot_next;
        s1_idx_reg    <= rd_addr;
        s1_op_reg     <= s1_op_next;
        s1_mand_reg   <= s1_mand_next;
        s1_pres_reg   <= presence_bit;
        s1_init_reg   <= has_initial;
        s1_data_reg   <= s1_data_next;
        s1_empty_reg  <= !desc_reg.mand && v_zero;
        byp_addr_reg  <= wr_addr;
        byp_entry_reg <= wr_entry;
    end

    fifd_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg),
        .push_data (res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (q_data),
        .count     (q_count)
    );

    assign field_slot  = q_data.slot;
    assign field_value = q_data.value;
    assign is_present  = q_data.present;
    assign status      = q_data.status;

`ifndef SYNTHESIS
    a_no_transfer_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !accept)
        else $error("Input transfer taken during the clearing pass.");

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        (q_count + OUT_CNT_W'(s1_valid_reg)) <= OUT_CNT_W'(OUT_DEPTH))
        else $error("Result queue can overflow.");

    a_write_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && (state_reg == ST_RUN)) |-> s1_valid_reg)
        else $error("Dictionary write without an item in the second stage.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (cnt_reg < CNT_W'(MAX_INT_BYTES)))
        else $error("Decode still active after the byte limit.");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> (q_count != '0))
        else $error("Second-stage item left no result in the queue.");
`endif

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// Testbench of the stop-bit integer field decoder: directed and random field streams against a predictor.
`default_nettype none
module testbench;
    import fifd_pkg::*;

    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;
    localparam logic [OP_W-1:0] OP_BAD_LOW  = 3'd5;
    localparam logic [OP_W-1:0] OP_BAD_HIGH = 3'd7;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int DRAIN_EVERY    = 600;
    localparam int HOLD_AFTER     = 500;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int FIELD_SLOTS_TB = DEF_FIELD_SLOTS;

    typedef struct {
        bit                 drain_first;
        logic               opcode;
        logic [BYTE_W-1:0]  stream_byte;
        logic [SLOT_W-1:0]  slot;
        logic [OP_W-1:0]    op;
        logic               sgn;
        logic               mand;
        logic               pres;
        logic               hasinit;
        logic [VALUE_W-1:0] init;
    } field_item_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                opcode = 1'b0;
    logic [BYTE_W-1:0]   stream_byte = '0;
    logic [SLOT_W-1:0]   slot = '0;
    logic [OP_W-1:0]     operator_kind = '0;
    logic                is_signed = 1'b0;
    logic                is_mandatory = 1'b0;
    logic                presence_bit = 1'b0;
    logic                has_initial = 1'b0;
    logic [VALUE_W-1:0]  initial_value = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [SLOT_W-1:0]   field_slot;
    logic [VALUE_W-1:0]  field_value;
    logic                is_present;
    logic [1:0]          status;

    field_item_t pending_items[$];
    result_t     expected_fields[$];
    field_item_t drive_item;
    logic        in_took = 1'b0;
    int          in_count = 0;
    int          total_items = 0;
    int          gen_count = 0;
    int          next_drain = 0;
    bit          drain_next = 0;
    int          mismatches = 0;
    int          gap_left = 0;
    int          burst_left = 1;
    int          hold_left = 0;
    bit          hold_done = 0;
    int          rx_mode = 0;
    int          rx_mode_left = 0;
    int          quiet_cycles = 0;

    logic [VALUE_W-1:0] slot_val[FIELD_SLOTS_TB];
    logic [1:0]         slot_st[FIELD_SLOTS_TB];
    logic [VALUE_W-1:0] dec_acc = '0;
    int                 dec_count = 0;
    bit                 dec_busy = 0;
    logic [SLOT_W-1:0]  held_slot = '0;
    logic [OP_W-1:0]    held_op = '0;
    logic               held_signed = 1'b0;
    logic               held_mand = 1'b0;

    fast_integer_field_decoder dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .opcode(opcode),
        .stream_byte(stream_byte),
        .slot(slot),
        .operator_kind(operator_kind),
        .is_signed(is_signed),
        .is_mandatory(is_mandatory),
        .presence_bit(presence_bit),
        .has_initial(has_initial),
        .initial_value(initial_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .field_slot(field_slot),
        .field_value(field_value),
        .is_present(is_present),
        .status(status)
    );

    always #2 clk = ~clk;

    function automatic logic [VALUE_W-1:0] wide_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 64'h7FFF_FFFF_FFFF_FFFF;
            3: return 64'h8000_0000_0000_0000;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic field_item_t begin_item(logic [SLOT_W-1:0] s, logic [OP_W-1:0] op,
                                               logic sgn, logic mand, logic pres,
                                               logic hasinit, logic [VALUE_W-1:0] init);
        field_item_t it;
        it.drain_first = 1'b0;
        it.opcode      = CMD_BEGIN;
        it.stream_byte = BYTE_W'($urandom);
        it.slot        = s;
        it.op          = op;
        it.sgn         = sgn;
        it.mand        = mand;
        it.pres        = pres;
        it.hasinit     = hasinit;
        it.init        = init;
        return it;
    endfunction

    function automatic field_item_t byte_item(logic [BYTE_W-1:0] b);
        field_item_t it;
        it = begin_item(SLOT_W'($urandom), OP_W'($urandom), 1'($urandom), 1'($urandom),
                        1'($urandom), 1'($urandom), {$urandom, $urandom});
        it.opcode      = CMD_BYTE;
        it.stream_byte = b;
        return it;
    endfunction

    function automatic result_t slot_report(logic [SLOT_W-1:0] s);
        result_t r;
        r.slot    = s;
        r.present = (slot_st[s] == SS_ASSIGNED);
        r.value   = r.present ? slot_val[s] : '0;
        r.status  = RES_OK;
        return r;
    endfunction

    task automatic decode_field(input field_item_t it, output bit emits, output result_t res);
        logic [VALUE_W-1:0] v;
        logic [SLOT_W-1:0]  idx;
        bit                 neg;
        emits = 0;
        res   = '0;
        idx   = it.slot;
        if (it.opcode == CMD_BYTE)
        begin
            if (!dec_busy)
                return;
            if (dec_count == 0 && held_signed && it.stream_byte[SIGN_BIT])
                dec_acc = '1;
            dec_acc = {dec_acc[VALUE_W-GROUP_W-1:0], it.stream_byte[GROUP_W-1:0]};
            dec_count++;
            if (it.stream_byte[STOP_BIT])
            begin
                dec_busy = 0;
                v   = dec_acc;
                neg = held_signed && v[VALUE_W-1];
                idx = held_slot;
                slot_st[idx] = SS_ASSIGNED;
                if (held_op == OP_DELTA)
                begin
                    if (!held_mand && v != '0 && !neg)
                        v = v - VALUE_W'(1);
                    slot_val[idx] = slot_val[idx] + v;
                end
                else
                begin
                    if (!held_mand)
                    begin
                        if (v == '0)
                            slot_st[idx] = SS_EMPTY;
                        else if (!neg)
                            v = v - VALUE_W'(1);
                    end
                    slot_val[idx] = v;
                end
                emits = 1;
                res = slot_report(held_slot);
            end
            else if (dec_count >= DEF_MAX_INT_BYTES)
            begin
                dec_busy   = 0;
                emits      = 1;
                res.slot   = held_slot;
                res.status = RES_OVERLONG;
            end
            return;
        end
        dec_busy = 0;
        if (it.op > OP_CONST)
        begin
            emits      = 1;
            res.slot   = it.slot;
            res.status = RES_BADOP;
            return;
        end
        if (it.op == OP_CONST)
        begin
            if (slot_st[idx] != SS_ASSIGNED)
                slot_val[idx] = it.init;
            slot_st[idx] = SS_ASSIGNED;
            if (!it.mand && !it.pres)
                slot_st[idx] = SS_EMPTY;
            emits = 1;
            res = slot_report(it.slot);
            return;
        end
        if ((it.op == OP_COPY || it.op == OP_INCR) && !it.pres)
        begin
            emits = 1;
            res.slot = it.slot;
            case (slot_st[idx])
                SS_UNDEF:
                begin
                    if (it.hasinit)
                    begin
                        slot_st[idx]  = SS_ASSIGNED;
                        slot_val[idx] = it.init;
                    end
                    else if (it.mand)
                    begin
                        res.status = RES_MISSING;
                        return;
                    end
                    else
                    begin
                        slot_st[idx] = SS_EMPTY;
                    end
                end
                SS_ASSIGNED:
                begin
                    if (it.op == OP_INCR)
                        slot_val[idx] = slot_val[idx] + VALUE_W'(1);
                end
                SS_EMPTY:
                begin
                    if (it.mand)
                    begin
                        res.status = RES_MISSING;
                        return;
                    end
                end
                default:
                begin
                end
            endcase
            res = slot_report(it.slot);
            return;
        end
        held_slot   = it.slot;
        held_op     = it.op;
        held_signed = it.sgn;
        held_mand   = it.mand;
        dec_acc     = '0;
        dec_count   = 0;
        dec_busy    = 1;
    endtask

    task automatic add_random_field();
        field_item_t        it;
        int                 r;
        int                 nbytes;
        bit                 stopped;
        bit                 tiny;
        logic [SLOT_W-1:0]  s;
        logic [OP_W-1:0]    op;
        logic [BYTE_W-1:0]  b;
        s = ($urandom_range(0, 9) < 8) ? SLOT_W'($urandom_range(0, 7))
                                       : SLOT_W'($urandom_range(0, 63));
        r = $urandom_range(0, 99);
        if (r >= 90)
        begin
            pending_items.push_back(byte_item(BYTE_W'($urandom)));
            return;
        end
        if (r < 55)
        begin
            case ($urandom_range(0, 3))
                0: op = OP_NONE;
                1: op = OP_DELTA;
                2: op = OP_COPY;
                default: op = OP_INCR;
            endcase
            it = begin_item(s, op, 1'($urandom), 1'($urandom),
                            (op == OP_COPY || op == OP_INCR) ? 1'b1 : 1'($urandom),
                            1'($urandom), wide_value());
        end
        else if (r < 85)
        begin
            case ($urandom_range(0, 2))
                0: op = OP_COPY;
                1: op = OP_INCR;
                default: op = OP_CONST;
            endcase
            it = begin_item(s, op, 1'($urandom), 1'($urandom),
                            (op == OP_CONST) ? 1'($urandom) : 1'b0,
                            1'($urandom), wide_value());
        end
        else
        begin
            it = begin_item(s, OP_W'($urandom_range(32'(OP_BAD_LOW), 32'(OP_BAD_HIGH))),
                            1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                            wide_value());
        end
        it.drain_first = drain_next;
        drain_next = 0;
        pending_items.push_back(it);
        gen_count++;
        if (r >= 55)
            return;
        tiny    = 0;
        stopped = 1;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            tiny   = 1;
            nbytes = 1;
        end
        else
        begin
            r = $urandom_range(0, 99);
            nbytes = (r < 60) ? $urandom_range(1, 3) :
                     (r < 90) ? $urandom_range(4, 8) : DEF_MAX_INT_BYTES;
            r = $urandom_range(0, 99);
            if (r >= 84 && r < 92)
            begin
                stopped = 0;
                nbytes  = DEF_MAX_INT_BYTES;
            end
            else if (r >= 92)
            begin
                stopped = 0;
                if (nbytes >= DEF_MAX_INT_BYTES)
                    nbytes = DEF_MAX_INT_BYTES - 1;
            end
        end
        for (int i = 0; i < nbytes; i++)
        begin
            b = BYTE_W'($urandom);
            if (tiny)
                b[STOP_BIT-1:1] = '0;
            b[STOP_BIT] = stopped && (i == nbytes - 1);
            pending_items.push_back(byte_item(b));
            gen_count++;
        end
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !in_took)
        begin
        end
        else if (gap_left > 0)
        begin
            gap_left <= gap_left - 1;
            in_valid <= 1'b0;
        end
        else if (pending_items.size() == 0 ||
                 (pending_items[0].drain_first && expected_fields.size() != 0))
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            drive_item = pending_items.pop_front();
            opcode        <= drive_item.opcode;
            stream_byte   <= drive_item.stream_byte;
            slot          <= drive_item.slot;
            operator_kind <= drive_item.op;
            is_signed     <= drive_item.sgn;
            is_mandatory  <= drive_item.mand;
            presence_bit  <= drive_item.pres;
            has_initial   <= drive_item.hasinit;
            initial_value <= drive_item.init;
            in_valid      <= 1'b1;
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(1, 60);
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end
            else
            begin
                burst_left <= burst_left - 1;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && in_count >= HOLD_AFTER)
        begin
            hold_done <= 1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode      <= $urandom_range(0, 3);
                rx_mode_left <= $urandom_range(8, 150);
            end
            else
            begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    always @(posedge clk)
    begin : monitor
        field_item_t taken;
        result_t     want;
        result_t     fresh;
        bit          emits;
        if (!rst_n)
        begin
            in_took <= 1'b0;
        end
        else
        begin
            in_took <= in_valid && !in_stall;
            if (out_valid && !out_stall)
            begin
                if (expected_fields.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: slot %0d value %h present %b status %0d",
                                 field_slot, field_value, is_present, status);
                end
                else
                begin
                    want = expected_fields.pop_front();
                    if (field_slot !== want.slot || field_value !== want.value ||
                        is_present !== want.present || status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: got %0d %h %b %0d, expected %0d %h %b %0d",
                                     field_slot, field_value, is_present, status,
                                     want.slot, want.value, want.present, want.status);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                taken.drain_first = 1'b0;
                taken.opcode      = opcode;
                taken.stream_byte = stream_byte;
                taken.slot        = slot;
                taken.op          = operator_kind;
                taken.sgn         = is_signed;
                taken.mand        = is_mandatory;
                taken.pres        = presence_bit;
                taken.hasinit     = has_initial;
                taken.init        = initial_value;
                decode_field(taken, emits, fresh);
                if (emits)
                    expected_fields.push_back(fresh);
                in_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < FIELD_SLOTS_TB; i++)
        begin
            slot_val[i] = '0;
            slot_st[i]  = SS_UNDEF;
        end
        // Immediate results: missing, empty, initial value, wrap, constant and bad operators.
        pending_items.push_back(begin_item(SLOT_W'(0), OP_COPY, 1'b0, 1'b1, 1'b0, 1'b0,
                                           wide_value()));
        pending_items.push_back(begin_item(SLOT_W'(1), OP_COPY, 1'b0, 1'b0, 1'b0, 1'b0,
                                           wide_value()));
        pending_items.push_back(begin_item(SLOT_W'(2), OP_INCR, 1'b1, 1'b1, 1'b0, 1'b1, '1));
        pending_items.push_back(begin_item(SLOT_W'(2), OP_INCR, 1'b1, 1'b1, 1'b0, 1'b0, '0));
        pending_items.push_back(begin_item(SLOT_W'(1), OP_COPY, 1'b0, 1'b1, 1'b0, 1'b1,
                                           64'h5));
        pending_items.push_back(begin_item(SLOT_W'(3), OP_CONST, 1'b0, 1'b1, 1'b0, 1'b0,
                                           64'h8000_0000_0000_0000));
        pending_items.push_back(begin_item(SLOT_W'(4), OP_CONST, 1'b1, 1'b0, 1'b0, 1'b1, '1));
        pending_items.push_back(begin_item(SLOT_W'(63), OP_BAD_HIGH, 1'b1, 1'b1, 1'b1, 1'b1,
                                           '1));
        // A signed field whose first byte carries the sign and the stop bit.
        pending_items.push_back(begin_item(SLOT_W'(6), OP_NONE, 1'b1, 1'b0, 1'b1, 1'b0, '0));
        pending_items.push_back(byte_item(8'hC0));
        // An unfinished integer dropped by a new begin, then an optional zero.
        pending_items.push_back(begin_item(SLOT_W'(8), OP_NONE, 1'b0, 1'b1, 1'b1, 1'b0, '0));
        pending_items.push_back(byte_item(8'h01));
        pending_items.push_back(begin_item(SLOT_W'(9), OP_COPY, 1'b0, 1'b0, 1'b1, 1'b0, '0));
        pending_items.push_back(byte_item(8'h80));
        // Optional delta of one adds nothing.
        pending_items.push_back(begin_item(SLOT_W'(2), OP_DELTA, 1'b0, 1'b0, 1'b1, 1'b0, '0));
        pending_items.push_back(byte_item(8'h81));
        // Overlong integer, then a byte that arrives while idle.
        pending_items.push_back(begin_item(SLOT_W'(10), OP_DELTA, 1'b1, 1'b1, 1'b1, 1'b0,
                                           '0));
        for (int i = 0; i < DEF_MAX_INT_BYTES; i++)
            pending_items.push_back(byte_item(8'h00));
        pending_items.push_back(byte_item(8'hFF));
        drain_next = 1;
        next_drain = DRAIN_EVERY;
        while (gen_count < RANDOM_ITEMS)
        begin
            if (gen_count >= next_drain)
            begin
                drain_next = 1;
                next_drain += DRAIN_EVERY;
            end
            add_random_field();
        end
        total_items = pending_items.size();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        wait (in_count == total_items);
        while (expected_fields.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_fields.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
